>>> hw/rtl/nfmt_pkg.sv
// nfmt_pkg: shared types and constants for the number to ascii formatter
// transaction structs, format codes, character codes and the digit-to-char map
// no dependencies
package nfmt_pkg;

  localparam int unsigned NUM_W  = 32;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned CHAR_W = 7;

  localparam logic [MODE_W-1:0] MODE_U16   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_S16   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIX   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HEX8  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HEX16 = 3'd4;

  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  // 'A' minus ten
  localparam logic [CHAR_W-1:0] CH_ALPHA_BASE = 7'h37;

  localparam logic [7:0] DIVISOR = 8'd100;

  typedef struct packed {
    logic [MODE_W-1:0]       req_type;
    logic signed [NUM_W-1:0] number_in;
  } nfmt_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last_char;
  } nfmt_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } nfmt_div_ctl_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] wide;
    wide = {3'b000, nib};
    if (nib < 4'd10) begin
      return CH_ZERO + wide;
    end
    return CH_ALPHA_BASE + wide;
  endfunction

endpackage

>>> hw/rtl/nfmt_div100.sv
// nfmt_div100: bit-serial restoring divide by one hundred
// one quotient bit per step over 32 steps; depends on nfmt_pkg
module nfmt_div100 (
  input  logic                          clk,
  input  nfmt_pkg::nfmt_div_ctl_t       ctl,
  input  logic [nfmt_pkg::NUM_W-1:0]    dividend,
  output logic [15:0]                   quo,
  output logic [6:0]                    rem
);
  import nfmt_pkg::*;

  logic [NUM_W-1:0] q_r;
  logic [6:0]       rem_r;
  logic [7:0]       trial;
  logic [7:0]       diff;
  logic             ge;

  // dividend bits leave at the top while quotient bits enter at the bottom
  assign trial = {rem_r, q_r[NUM_W-1]};
  assign ge    = (trial >= DIVISOR);
  assign diff  = trial - DIVISOR;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (ctl.step) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[6:0] : trial[6:0];
    end
  end

  assign quo = q_r[15:0];
  assign rem = rem_r;

endmodule

>>> hw/rtl/number_to_ascii_formatter_core.sv
// number_to_ascii_formatter_core: formats one number as ascii text, one char per strobe
// depends on nfmt_pkg and nfmt_div100
// busy after accept: u16/s16 and fixed run the bit-serial double-dabble (16 shifts),
// fixed first runs the divide by 100 (32 steps), a '-' adds a sign state, and hex8
// and hex16 go straight to their digits; one item at a time
// unused format codes are dropped with no result and busy stays low
// synchronous active-low reset returns to idle with no strobe pending
module number_to_ascii_formatter_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  nfmt_pkg::nfmt_in_t  in_data,
  output logic                out_valid,
  output nfmt_pkg::nfmt_out_t out_data
);
  import nfmt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIV,
    ST_LOAD,
    ST_CONV,
    ST_SKIP,
    ST_DIGITS,
    ST_DOT,
    ST_FRAC_HI,
    ST_FRAC_LO
  } state_t;

  localparam logic [4:0] DIV_LAST  = 5'd31;
  localparam logic [4:0] CONV_LAST = 5'd15;
  localparam logic [2:0] DEC_DIGS  = 3'd5;

  state_t            state_r;
  logic              fixed_r;
  logic [4:0]        cnt_r;
  logic [2:0]        dcnt_r;
  logic [15:0]       work_r;
  logic [15:0]       fsh_r;
  logic [19:0]       bcd_r;
  logic [7:0]        fbcd_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  logic [NUM_W-1:0]  raw;
  logic [NUM_W-1:0]  mag32;
  logic [15:0]       mag16;
  logic [19:0]       bcd_adj;
  logic [7:0]        fbcd_adj;
  logic              accept;
  nfmt_div_ctl_t     div_ctl;
  logic [15:0]       div_quo;
  logic [6:0]        div_rem;

  assign raw    = in_data.number_in;
  assign mag32  = raw[NUM_W-1] ? (32'd0 - raw) : raw;
  assign mag16  = raw[15] ? (16'd0 - raw[15:0]) : raw[15:0];
  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    div_ctl.load = accept && (in_data.req_type == MODE_FIX);
    div_ctl.step = (state_r == ST_DIV);
  end

  nfmt_div100 u_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (mag32),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // add-3 correction ahead of each double-dabble shift
  always_comb begin
    bcd_adj  = bcd_r;
    fbcd_adj = fbcd_r;
    for (int i = 0; i < 5; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end
    end
    for (int j = 0; j < 2; j++) begin
      if (fbcd_r[j*4 +: 4] >= 4'd5) begin
        fbcd_adj[j*4 +: 4] = fbcd_r[j*4 +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            cnt_r   <= '0;
            bcd_r   <= '0;
            fbcd_r  <= '0;
            fsh_r   <= '0;
            fixed_r <= (in_data.req_type == MODE_FIX);
            case (in_data.req_type)
              MODE_U16: begin
                work_r  <= raw[15:0];
                state_r <= ST_CONV;
              end
              MODE_S16: begin
                work_r  <= mag16;
                state_r <= raw[15] ? ST_SIGN : ST_CONV;
              end
              MODE_FIX: begin
                state_r <= raw[NUM_W-1] ? ST_SIGN : ST_DIV;
              end
              MODE_HEX8: begin
                bcd_r   <= {raw[7:0], 12'h000};
                dcnt_r  <= 3'd2;
                state_r <= ST_DIGITS;
              end
              MODE_HEX16: begin
                bcd_r   <= {raw[15:0], 4'h0};
                dcnt_r  <= 3'd4;
                state_r <= ST_DIGITS;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SIGN: begin
          out_valid_r <= 1'b1;
          out_char_r  <= CH_MINUS;
          state_r     <= fixed_r ? ST_DIV : ST_CONV;
        end
        ST_DIV: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == DIV_LAST) begin
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          work_r  <= div_quo;
          fsh_r   <= {9'd0, div_rem};
          cnt_r   <= '0;
          state_r <= ST_CONV;
        end
        ST_CONV: begin
          bcd_r  <= {bcd_adj[18:0], work_r[15]};
          fbcd_r <= {fbcd_adj[6:0], fsh_r[15]};
          work_r <= {work_r[14:0], 1'b0};
          fsh_r  <= {fsh_r[14:0], 1'b0};
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == CONV_LAST) begin
            dcnt_r  <= DEC_DIGS;
            state_r <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // drop leading zeros, keeping at least one digit
          if ((bcd_r[19:16] == 4'd0) && (dcnt_r > 3'd1)) begin
            bcd_r  <= {bcd_r[15:0], 4'h0};
            dcnt_r <= dcnt_r - 3'd1;
          end else begin
            state_r <= ST_DIGITS;
          end
        end
        ST_DIGITS: begin
          out_valid_r <= 1'b1;
          out_char_r  <= hex_char(bcd_r[19:16]);
          bcd_r       <= {bcd_r[15:0], 4'h0};
          dcnt_r      <= dcnt_r - 3'd1;
          if (dcnt_r == 3'd1) begin
            if (fixed_r) begin
              state_r <= ST_DOT;
            end else begin
              out_last_r <= 1'b1;
              state_r    <= ST_IDLE;
            end
          end
        end
        ST_DOT: begin
          out_valid_r <= 1'b1;
          out_char_r  <= CH_DOT;
          state_r     <= ST_FRAC_HI;
        end
        ST_FRAC_HI: begin
          out_valid_r <= 1'b1;
          out_char_r  <= hex_char(fbcd_r[7:4]);
          state_r     <= ST_FRAC_LO;
        end
        ST_FRAC_LO: begin
          out_valid_r <= 1'b1;
          out_char_r  <= hex_char(fbcd_r[3:0]);
          out_last_r  <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_data.char_out  = out_char_r;
  assign out_data.last_char = out_last_r;

endmodule

>>> hw/rtl/nfmt_checker.sv
// nfmt_checker: port-level assertions for number_to_ascii_formatter_core
// attached by the bind at the end of this file; depends on nfmt_pkg
module nfmt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input nfmt_pkg::nfmt_in_t  in_data,
  input logic                out_valid,
  input nfmt_pkg::nfmt_out_t out_data
);
  import nfmt_pkg::*;

  logic known_mode;
  assign known_mode = (in_data.req_type == MODE_U16) || (in_data.req_type == MODE_S16) ||
                      (in_data.req_type == MODE_FIX) || (in_data.req_type == MODE_HEX8) ||
                      (in_data.req_type == MODE_HEX16);

  // a known format always starts work
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && known_mode |=> busy)
    else $error("accepted transaction did not raise busy");

  // an unused format code leaves the block idle and silent
  a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !known_mode |=> !busy && !out_valid)
    else $error("unused format code produced activity");

  // only the final character may appear once busy is gone
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_char |-> busy)
    else $error("non-final character while not busy");

  // work ends only with the final character
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid && out_data.last_char)
    else $error("busy dropped without a final character");

  // a new transaction cannot emit in the cycle after a final character
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_char |=> !out_valid)
    else $error("character right after final character");

endmodule

bind number_to_ascii_formatter_core nfmt_checker u_nfmt_checker (.*);

>>> tb/tb_number_to_ascii_formatter_core.sv
`timescale 1ns / 100ps
// tb_number_to_ascii_formatter_core: self-checking bench for the number to ascii formatter
// drives a directed table and random numbers in every format, checks chars against expected text or a predictor
// depends on nfmt_pkg and number_to_ascii_formatter_core
module tb_number_to_ascii_formatter_core;
  import nfmt_pkg::*;

  // format codes the core drops without output
  localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RAND_ITEMS   = 90;
  localparam int TAIL_ITEMS   = 20;
  localparam int DRAIN_CYCLES = 100;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  nfmt_in_t  in_data;
  logic      out_valid;
  nfmt_out_t out_data;

  nfmt_out_t         exp_chars [$];
  logic [MODE_W-1:0] row_mode [$];
  logic [NUM_W-1:0]  row_num [$];
  string             row_text [$];
  int                errors = 0;
  int                idle_cycles = 0;

  always #5 clk = ~clk;

  number_to_ascii_formatter_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  function automatic void push_char(input logic [CHAR_W-1:0] c);
    nfmt_out_t r;
    r.char_out  = c;
    r.last_char = 1'b0;
    exp_chars.push_back(r);
  endfunction

  function automatic void mark_last();
    nfmt_out_t r;
    r = exp_chars.pop_back();
    r.last_char = 1'b1;
    exp_chars.push_back(r);
  endfunction

  // decimal text of a 16-bit value, no leading zeros
  function automatic void push_dec16(input logic [15:0] v);
    logic [CHAR_W-1:0] digs [5];
    logic [15:0]       rest;
    int                k;
    rest = v;
    k = 0;
    if (rest == 16'd0) begin
      push_char(CH_ZERO);
      return;
    end
    while (rest != 16'd0) begin
      digs[k] = CH_ZERO + CHAR_W'(rest % 16'd10);
      rest = rest / 16'd10;
      k++;
    end
    while (k > 0) begin
      k--;
      push_char(digs[k]);
    end
  endfunction

  function automatic void predict_text(input nfmt_in_t item);
    logic [31:0] raw;
    logic [31:0] mag;
    logic [31:0] frac;
    logic [15:0] v16;
    logic [3:0]  nib;
    int          prior_len;
    int          i;
    raw = item.number_in;
    prior_len = exp_chars.size();
    case (item.req_type)
      MODE_U16: begin
        push_dec16(raw[15:0]);
      end
      MODE_S16: begin
        v16 = raw[15:0];
        if (v16[15]) begin
          push_char(CH_MINUS);
          v16 = -v16;
        end
        push_dec16(v16);
      end
      MODE_FIX: begin
        mag = raw;
        if (raw[31]) begin
          push_char(CH_MINUS);
          mag = -raw;
        end
        frac = mag % 32'd100;
        // whole part wraps to 16 bits
        push_dec16(16'(mag / 32'd100));
        push_char(CH_DOT);
        push_char(CH_ZERO + CHAR_W'(frac / 32'd10));
        push_char(CH_ZERO + CHAR_W'(frac % 32'd10));
      end
      MODE_HEX8, MODE_HEX16: begin
        for (i = (item.req_type == MODE_HEX8) ? 1 : 3; i >= 0; i--) begin
          nib = raw[i*4 +: 4];
          push_char((nib < 4'd10) ? CH_ZERO + CHAR_W'(nib) : CH_ALPHA_BASE + CHAR_W'(nib));
        end
      end
      default: begin
      end
    endcase
    if (exp_chars.size() > prior_len) mark_last();
  endfunction

  function automatic void add_row(input logic [MODE_W-1:0] m, input logic [NUM_W-1:0] num,
                                  input string text);
    row_mode.push_back(m);
    row_num.push_back(num);
    row_text.push_back(text);
  endfunction

  // holds start until the transaction is taken
  task automatic send_number(input nfmt_in_t item);
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (exp_chars.size() != 0);
  endtask

  task automatic maybe_idle(input bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : char_check
    nfmt_out_t want;
    if (rst_n && out_valid) begin
      if (exp_chars.size() == 0) begin
        $error("char_out: expected none, actual 0x%0h", out_data.char_out);
        errors++;
      end else begin
        want = exp_chars.pop_front();
        if (out_data.char_out !== want.char_out) begin
          $error("char_out: expected 0x%0h, actual 0x%0h", want.char_out, out_data.char_out);
          errors++;
        end
        if (out_data.last_char !== want.last_char) begin
          $error("last_char: expected %0b, actual %0b", want.last_char, out_data.last_char);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("number_to_ascii_formatter_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    nfmt_in_t    item;
    logic [31:0] num;
    string       txt;
    int          i;
    int          j;
    int          taken;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;

    add_row(MODE_U16,   32'h0000_0000, "0");
    add_row(MODE_U16,   32'h0000_FFFF, "65535");
    add_row(MODE_U16,   32'hFFFF_0001, "1");
    add_row(MODE_U16,   32'h0000_000A, "10");
    add_row(MODE_S16,   32'h0000_8000, "-32768");
    add_row(MODE_S16,   32'h0000_7FFF, "32767");
    add_row(MODE_S16,   32'hFFFF_FFFF, "-1");
    add_row(MODE_S16,   32'h1234_8001, "-32767");
    add_row(MODE_RSVD5, 32'hFFFF_FFFF, "");
    add_row(MODE_S16,   32'hFFFF_0000, "0");
    add_row(MODE_FIX,   32'h0000_0000, "0.00");
    add_row(MODE_FIX,   32'h8000_0000, "");
    add_row(MODE_FIX,   32'h7FFF_FFFF, "");
    add_row(MODE_FIX,   32'd6553599,   "65535.99");
    add_row(MODE_FIX,   32'd6553600,   "0.00");
    add_row(MODE_FIX,   32'hFFFF_FFFF, "-0.01");
    add_row(MODE_FIX,   32'd5,         "0.05");
    add_row(MODE_RSVD6, 32'h5555_AAAA, "");
    add_row(MODE_HEX8,  32'h0000_00AB, "AB");
    add_row(MODE_HEX8,  32'h0000_0000, "00");
    add_row(MODE_HEX8,  32'hFFFF_FF5F, "5F");
    add_row(MODE_HEX16, 32'h0000_FFFF, "FFFF");
    add_row(MODE_HEX16, 32'h1234_0000, "0000");
    add_row(MODE_HEX16, 32'h0000_C0DE, "C0DE");
    add_row(MODE_RSVD7, 32'h0000_0000, "");

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < row_mode.size(); i++) begin
      item.req_type  = row_mode[i];
      item.number_in = row_num[i];
      send_number(item);
      txt = row_text[i];
      if (txt.len() == 0) begin
        predict_text(item);
      end else begin
        for (j = 0; j < txt.len(); j++) push_char(CHAR_W'(txt[j]));
        mark_last();
      end
      maybe_idle(1'b1);
    end
    wait_drained();

    taken = 0;
    while (taken < RAND_ITEMS) begin
      case ($urandom_range(0, 11))
        0, 1:    item.req_type = MODE_U16;
        2, 3:    item.req_type = MODE_S16;
        4, 5, 6: item.req_type = MODE_FIX;
        7, 8:    item.req_type = MODE_HEX8;
        9, 10:   item.req_type = MODE_HEX16;
        default: item.req_type = MODE_RSVD5 + MODE_W'($urandom_range(0, 2));
      endcase
      case ($urandom_range(0, 3))
        0:       num = $urandom();
        1:       num = $urandom_range(0, 999);
        2:       num = {16'($urandom()), 16'($urandom_range(32760, 32775))};
        default: num = $urandom_range(0, 6553700);
      endcase
      if ($urandom_range(0, 1) == 1) num = -num;
      item.number_in = num;
      send_number(item);
      predict_text(item);
      if (item.req_type != MODE_RSVD5 && item.req_type != MODE_RSVD6 &&
          item.req_type != MODE_RSVD7) taken++;
      // sender holds off until the core has emitted everything
      if (taken % 40 == 20) begin
        wait_drained();
      end else begin
        maybe_idle(taken < RAND_ITEMS - TAIL_ITEMS);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("number_to_ascii_formatter_core regression: pass");
    end else begin
      $display("number_to_ascii_formatter_core regression: fail");
    end
    $finish;
  end

endmodule

>>> number_to_ascii_formatter_core.f
hw/rtl/nfmt_pkg.sv
hw/rtl/nfmt_div100.sv
hw/rtl/number_to_ascii_formatter_core.sv
hw/rtl/nfmt_checker.sv
tb/tb_number_to_ascii_formatter_core.sv
